[rtl/rhc_pkg.sv]
`timescale 1ns / 1ps
package rhc_pkg;

    localparam int CordicSteps = 16;
    localparam int DivSteps    = 8;
    localparam int NumStages   = CordicSteps + 1;
    localparam int XyW         = 25;
    localparam int AngW        = 18;
    localparam int RemW        = 18;
    localparam int SumW        = 10;

    localparam logic signed [AngW-1:0] HalfTurn = AngW'(32768);
    localparam logic signed [13:0]     Sqrt3Q12 = 14'sd7094;
    localparam logic [9:0]             RecipThird = 10'd683;

    typedef struct packed {
        logic                   valid;
        logic signed [XyW-1:0]  x;
        logic signed [XyW-1:0]  y;
        logic signed [AngW-1:0] ang;
        logic [RemW-1:0]        rem;
        logic [7:0]             quo;
        logic [SumW-1:0]        sum;
        logic                   gray;
        logic                   g_eq_b;
        logic                   r_gt_g;
        logic                   g_gt_b;
    } t_stage;

    typedef struct packed {
        logic       valid;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] intensity;
    } t_result;

    // atan(2^-i) in 1/65536 turn units
    function automatic logic [13:0] atan_turns(input int idx);
        logic [13:0] v;
        unique case (idx)
            0:  v = 14'd8192;
            1:  v = 14'd4836;
            2:  v = 14'd2555;
            3:  v = 14'd1297;
            4:  v = 14'd651;
            5:  v = 14'd326;
            6:  v = 14'd163;
            7:  v = 14'd81;
            8:  v = 14'd41;
            9:  v = 14'd20;
            10: v = 14'd10;
            11: v = 14'd5;
            12: v = 14'd3;
            13: v = 14'd1;
            14: v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // one cordic rotation plus, in the early stages, one quotient bit
    function automatic t_stage stage_step(input t_stage s, input int idx);
        t_stage                 o;
        logic signed [AngW-1:0] da;
        logic signed [RemW:0]   trial;
        logic [RemW-1:0]        dvs;
        o  = s;
        da = AngW'(signed'({1'b0, atan_turns(idx)}));
        if (s.y > 0) begin
            o.x   = s.x + (s.y >>> idx);
            o.y   = s.y - (s.x >>> idx);
            o.ang = s.ang + da;
        end else begin
            o.x   = s.x - (s.y >>> idx);
            o.y   = s.y + (s.x >>> idx);
            o.ang = s.ang - da;
        end
        if (idx < DivSteps) begin
            dvs   = RemW'(s.sum) << (DivSteps - 1 - idx);
            trial = signed'({1'b0, s.rem}) - signed'({1'b0, dvs});
            if (trial >= 0) begin
                o.rem = trial[RemW-1:0];
                o.quo[DivSteps - 1 - idx] = 1'b1;
            end else begin
                o.quo[DivSteps - 1 - idx] = 1'b0;
            end
        end
        return o;
    endfunction

endpackage

[rtl/rhc_if.sv]
`timescale 1ns / 1ps
interface rhc_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsi_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
    modport source (output valid, hue, saturation, intensity, input ready);
    modport sink   (input valid, hue, saturation, intensity, output ready);
endinterface

[rtl/rgb_to_hsi_pixel_converter_unit.sv]
`timescale 1ns / 1ps
// channel   dir  word
// i_pix     in   red, green, blue (8 bit each)
// o_pix     out  hue, saturation, intensity (8 bit each)
//
// one word per clock while o_pix does not stall, registered through every stage up to o_pix.valid
// depth is set by the sixteen cordic rotation stages plus entry and output
// i_rst_n synchronous, clears the valid bits only
// a stall at o_pix freezes the whole pipeline; i_pix.ready drops with it
module rgb_to_hsi_pixel_converter_unit
    import rhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_rgb_if.sink    i_pix,
    rhc_hsi_if.source  o_pix
);

    t_stage  r_stg [0:NumStages-1];
    t_stage  n_stg [0:NumStages-1];
    t_result r_out;
    t_result n_out;
    logic    w_en;

    // global advance: move when the output slot is free or being taken
    assign w_en        = !r_out.valid || o_pix.ready;
    assign i_pix.ready = w_en;

    // entry stage: chroma vector, half-turn pre-rotation, divider setup
    logic [7:0]             w_mn;
    logic signed [10:0]     w_d1;
    logic signed [8:0]      w_d2;
    logic signed [XyW-1:0]  w_x;
    logic signed [XyW-1:0]  w_y;
    logic [SumW-1:0]        w_diff;

    always_comb begin
        w_mn = i_pix.red;
        if (i_pix.green < w_mn) w_mn = i_pix.green;
        if (i_pix.blue  < w_mn) w_mn = i_pix.blue;
        w_d1 = 11'(signed'({3'b0, i_pix.red}) * 2)
             - signed'({3'b0, i_pix.green}) - signed'({3'b0, i_pix.blue});
        w_d2 = signed'({1'b0, i_pix.green}) - signed'({1'b0, i_pix.blue});
        w_x  = XyW'(w_d1) <<< 12;
        w_y  = XyW'(w_d2) * XyW'(Sqrt3Q12);
        n_stg[0].valid  = i_pix.valid;
        n_stg[0].sum    = SumW'(i_pix.red) + SumW'(i_pix.green) + SumW'(i_pix.blue);
        w_diff          = SumW'(n_stg[0].sum - 3 * SumW'(w_mn));
        // 255 * diff as a shift and subtract
        n_stg[0].rem    = (RemW'(w_diff) << 8) - RemW'(w_diff);
        n_stg[0].quo    = '0;
        n_stg[0].gray   = (i_pix.red == i_pix.green) && (i_pix.green == i_pix.blue);
        n_stg[0].g_eq_b = (i_pix.green == i_pix.blue);
        n_stg[0].r_gt_g = (i_pix.red > i_pix.green);
        n_stg[0].g_gt_b = (i_pix.green > i_pix.blue);
        if (w_x < 0) begin
            // turn by half a circle into the right half plane
            n_stg[0].x   = -w_x;
            n_stg[0].y   = -w_y;
            n_stg[0].ang = (w_y >= 0) ? HalfTurn : -HalfTurn;
        end else begin
            n_stg[0].x   = w_x;
            n_stg[0].y   = w_y;
            n_stg[0].ang = '0;
        end
    end

    // rotation stages, the first eight also retire one quotient bit
    for (genvar s = 1; s < NumStages; s++) begin : g_stage
        assign n_stg[s] = stage_step(r_stg[s-1], s - 1);
    end

    for (genvar s = 0; s < NumStages; s++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[s].valid <= 1'b0;
            end else if (w_en) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    // output stage: angle clamp per half circle, special cases, sum / 3
    t_stage                 w_last;
    logic signed [AngW-1:0] w_ang;
    logic [19:0]            w_third;

    always_comb begin
        w_last = r_stg[NumStages-1];
        w_ang  = w_last.ang;
        if (w_last.g_gt_b) begin
            if (w_ang < 0)        w_ang = '0;
            if (w_ang > HalfTurn) w_ang = HalfTurn;
        end else begin
            if (w_ang < -HalfTurn) w_ang = -HalfTurn;
            if (w_ang > -1)        w_ang = '1;
        end
        n_out.valid = w_last.valid;
        if (w_last.gray) begin
            n_out.hue = 8'd0;
        end else if (w_last.g_eq_b) begin
            n_out.hue = w_last.r_gt_g ? 8'd0 : 8'd128;
        end else begin
            // low sixteen bits wrap the lower half circle up by a full turn
            n_out.hue = w_ang[15:8];
        end
        n_out.saturation = (w_last.sum == '0) ? 8'd0 : w_last.quo;
        w_third          = 20'(w_last.sum) * 20'(RecipThird);
        n_out.intensity  = w_third[18:11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid      = r_out.valid;
    assign o_pix.hue        = r_out.hue;
    assign o_pix.saturation = r_out.saturation;
    assign o_pix.intensity  = r_out.intensity;

    // a finished word is never dropped while waiting
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && !o_pix.ready) |=> r_out.valid)
        else $error("output word lost under stall");

    // a word leaving the last stage lands in the output register
    a_land: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_stg[NumStages-1].valid) |=> r_out.valid)
        else $error("pipeline word not delivered");

    // a black pixel reports zero saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_stg[NumStages-1].valid && r_stg[NumStages-1].sum == '0)
        |=> (r_out.saturation == 8'd0))
        else $error("black pixel with saturation");

endmodule
